// ===== rtl/rig_pkg.sv =====
// shared constants, types and the gamma table builder for the pixel transform
package rig_pkg;

  localparam int CHAN_W            = 8;
  localparam int GAMMA_INDEX_SHIFT = 14;
  localparam int TABLE_SHIFT       = 14;
  localparam int TABLE_LAST        = 1020;
  localparam int IDX_W             = $clog2(TABLE_LAST + 1);

  // luminance weights in q16, they sum to 65536
  localparam int W_RED   = 13933;
  localparam int W_GREEN = 46871;
  localparam int W_BLUE  = 4732;

  // full-scale sum is 255 * 65536, fits in 24 bits
  localparam int SUM_W      = 24;
  localparam int UP_SHIFT   = (GAMMA_INDEX_SHIFT > TABLE_SHIFT) ?
                              (GAMMA_INDEX_SHIFT - TABLE_SHIFT) : 0;
  localparam int DOWN_SHIFT = (GAMMA_INDEX_SHIFT < TABLE_SHIFT) ?
                              (TABLE_SHIFT - GAMMA_INDEX_SHIFT) : 0;
  localparam int SCALE_W    = SUM_W + UP_SHIFT;

  localparam logic MODE_INVERT = 1'b0;
  localparam logic MODE_GRAY   = 1'b1;

  localparam int BIG_W = 256;

  typedef logic [CHAN_W-1:0] gray_rom_t [TABLE_LAST+1];

  // per-request side data that travels with the luminance index
  typedef struct packed {
    logic              valid;
    logic              mode;
    logic              row_end;
    logic [CHAN_W-1:0] inv_blue;
    logic [CHAN_W-1:0] inv_green;
    logic [CHAN_W-1:0] inv_red;
  } rig_side_t;

  function automatic logic [BIG_W-1:0] big_pow(input logic [BIG_W-1:0] base, input int n);
    logic [BIG_W-1:0] acc;
    acc = BIG_W'(1);
    for (int i = 0; i < n; i++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // exact test of 255*g(k/1020) >= v on the power-law branch
  function automatic logic at_least(input int k, input int v);
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    lhs = big_pow(BIG_W'(10761), 12) * big_pow(BIG_W'(k), 5);
    rhs = big_pow(BIG_W'(40 * v + 561), 12) * big_pow(BIG_W'(TABLE_LAST), 5);
    return lhs >= rhs;
  endfunction

  function automatic gray_rom_t build_gray_rom();
    gray_rom_t rom;
    int        v;
    v = 0;
    for (int k = 0; k <= 3; k++) begin
      rom[k] = CHAN_W'((323 * k) / 100);
    end
    for (int k = 4; k <= TABLE_LAST; k++) begin
      while (v < 255 && at_least(k, v + 1)) begin
        v = v + 1;
      end
      rom[k] = CHAN_W'(v);
    end
    return rom;
  endfunction

endpackage

// ===== rtl/rig_luma.sv =====
// luminance stages: weighted products, then sum, scale and clamp to a table index
module rig_luma import rig_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              mode,
  input  logic [CHAN_W-1:0] blue_in,
  input  logic [CHAN_W-1:0] green_in,
  input  logic [CHAN_W-1:0] red_in,
  input  logic              row_end_in,
  output rig_side_t         side,
  output logic [IDX_W-1:0]  index
);

  rig_side_t          side1;
  logic [SUM_W-1:0]   prod_red;
  logic [SUM_W-1:0]   prod_green;
  logic [SUM_W-1:0]   prod_blue;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   shifted;
  logic [SCALE_W-1:0] scaled;
  logic [IDX_W-1:0]   index_next;

  // stage 1: constant-weight products
  always_ff @(posedge clk) begin
    if (rst) begin
      side1.valid <= 1'b0;
    end else begin
      side1.valid <= take;
    end
    side1.mode      <= mode;
    side1.row_end   <= row_end_in;
    side1.inv_blue  <= ~blue_in;
    side1.inv_green <= ~green_in;
    side1.inv_red   <= ~red_in;
    prod_red        <= SUM_W'(W_RED) * SUM_W'(red_in);
    prod_green      <= SUM_W'(W_GREEN) * SUM_W'(green_in);
    prod_blue       <= SUM_W'(W_BLUE) * SUM_W'(blue_in);
  end

  always_comb begin
    sum     = prod_red + prod_green + prod_blue;
    shifted = sum >> GAMMA_INDEX_SHIFT;
    scaled  = (SCALE_W'(shifted) << UP_SHIFT) >> DOWN_SHIFT;
    if (scaled > SCALE_W'(TABLE_LAST)) begin
      index_next = IDX_W'(TABLE_LAST);
    end else begin
      index_next = scaled[IDX_W-1:0];
    end
  end

  // stage 2: table index
  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side.valid <= side1.valid;
    end
    side.mode      <= side1.mode;
    side.row_end   <= side1.row_end;
    side.inv_blue  <= side1.inv_blue;
    side.inv_green <= side1.inv_green;
    side.inv_red   <= side1.inv_red;
    index          <= index_next;
  end

endmodule

// ===== rtl/rig_gamma_rom.sv =====
// gamma table lookup and output register stage
module rig_gamma_rom import rig_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  rig_side_t         side,
  input  logic [IDX_W-1:0]  index,
  output logic              done,
  output logic              out_mode,
  output logic [CHAN_W-1:0] blue_out,
  output logic [CHAN_W-1:0] green_out,
  output logic [CHAN_W-1:0] red_out,
  output logic              row_end_out
);

  localparam gray_rom_t GRAY_ROM = build_gray_rom();

  logic [CHAN_W-1:0] gray;

  always_comb begin
    gray = GRAY_ROM[index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side.valid;
    end
    out_mode    <= side.mode;
    row_end_out <= side.row_end;
    if (side.mode == MODE_GRAY) begin
      blue_out  <= gray;
      green_out <= gray;
      red_out   <= gray;
    end else begin
      blue_out  <= side.inv_blue;
      green_out <= side.inv_green;
      red_out   <= side.inv_red;
    end
  end

endmodule

// ===== rtl/rgb_invert_or_grayscale.sv =====
// top level: per-pixel invert or grayscale transform (bt.709 luma weights, srgb gamma encoding)
//
// usage:
//   a request is taken at a rising edge with start high; busy is always low,
//   so one pixel may be sent every clock.
//   each result shows on blue_out/green_out/red_out/row_end_out for one cycle
//   with done high; the receiver has no way to hold it off.
//   pipeline: three register stages (weighted products, sum and index clamp,
//   gamma table read with output register). throughput is one pixel a clock.
//   mode is written with cfg_we/cfg_wdata; write it only while no requests
//   are in flight. mode 0 complements each byte, mode 1 writes the gamma
//   encoded luminance to all three channels.
//   reset (rst, synchronous) clears mode to invert and drops every request
//   still in the pipeline; the gamma table is a constant and needs no fill.
module rgb_invert_or_grayscale import rig_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic [CHAN_W-1:0] blue_in,
  input  logic [CHAN_W-1:0] green_in,
  input  logic [CHAN_W-1:0] red_in,
  input  logic              row_end_in,
  output logic              done,
  output logic [CHAN_W-1:0] blue_out,
  output logic [CHAN_W-1:0] green_out,
  output logic [CHAN_W-1:0] red_out,
  output logic              row_end_out
);

  logic             mode;
  logic             take;
  logic             out_mode;
  rig_side_t        side;
  logic [IDX_W-1:0] index;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_INVERT;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  rig_luma u_luma (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .mode       (mode),
    .blue_in    (blue_in),
    .green_in   (green_in),
    .red_in     (red_in),
    .row_end_in (row_end_in),
    .side       (side),
    .index      (index)
  );

  rig_gamma_rom u_rom (
    .clk         (clk),
    .rst         (rst),
    .side        (side),
    .index       (index),
    .done        (done),
    .out_mode    (out_mode),
    .blue_out    (blue_out),
    .green_out   (green_out),
    .red_out     (red_out),
    .row_end_out (row_end_out)
  );

`ifndef SYNTHESIS
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    take |-> ##3 done)
    else $error("request did not complete after three cycles");

  a_done_start: assert property (@(posedge clk)
    done |-> $past(take, 3))
    else $error("result without a matching request");

  a_gray_equal: assert property (@(posedge clk)
    (done && out_mode == MODE_GRAY) |-> (red_out == green_out && green_out == blue_out))
    else $error("gray result channels differ");

  a_invert: assert property (@(posedge clk)
    (done && out_mode == MODE_INVERT) |->
      (red_out == ~$past(red_in, 3) && blue_out == ~$past(blue_in, 3)))
    else $error("inverted result does not match the request");

  a_row_end: assert property (@(posedge clk)
    done |-> (row_end_out == $past(row_end_in, 3)))
    else $error("row end flag lost");
`endif

endmodule

// ===== test/tb_rgb_invert_or_grayscale.sv =====
// testbench for the invert / gamma grayscale block: corner and random pixels checked per field
module tb_rgb_invert_or_grayscale;
  timeunit 1ns;
  timeprecision 1ps;
  import rig_pkg::*;

  localparam int PIPE_DEPTH = 3;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 305;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              row_end;
  } pixel_t;

  class pixel_ledger;
    logic [CHAN_W-1:0] gamma_lut [0:TABLE_LAST];
    logic              mode;
    pixel_t            expected_pixels [$];
    int                mismatches;

    function new();
      mode = MODE_INVERT;
      mismatches = 0;
      build_gamma();
    endfunction

    // for k >= 4, entry k is the largest v with k^5 * 10761^12 >= (40v+561)^12 * 1020^5
    function void build_gamma();
      logic [255:0] top;
      logic [255:0] lhs;
      logic [255:0] bound [0:255];
      int           v;
      top = 256'(1);
      for (int i = 0; i < 12; i++) top = top * 256'(10761);
      for (int w = 0; w < 256; w++) begin
        bound[w] = 256'(1);
        for (int i = 0; i < 12; i++) bound[w] = bound[w] * 256'(40 * w + 561);
        for (int i = 0; i < 5; i++) bound[w] = bound[w] * 256'(TABLE_LAST);
      end
      // linear segment near black
      for (int k = 0; k <= 3; k++) gamma_lut[k] = CHAN_W'((323 * k) / 100);
      v = 0;
      for (int k = 4; k <= TABLE_LAST; k++) begin
        lhs = top;
        for (int i = 0; i < 5; i++) lhs = lhs * 256'(k);
        while (v < 255 && lhs >= bound[v + 1]) v++;
        gamma_lut[k] = CHAN_W'(v);
      end
    endfunction

    function pixel_t transform_pixel(pixel_t px);
      pixel_t      res;
      int unsigned luma;
      int unsigned idx;
      int          up;
      int          down;
      res.row_end = px.row_end;
      if (mode == MODE_GRAY) begin
        up = (GAMMA_INDEX_SHIFT > TABLE_SHIFT) ? GAMMA_INDEX_SHIFT - TABLE_SHIFT : 0;
        down = (GAMMA_INDEX_SHIFT < TABLE_SHIFT) ? TABLE_SHIFT - GAMMA_INDEX_SHIFT : 0;
        luma = 13933 * int'(px.red) + 46871 * int'(px.green) + 4732 * int'(px.blue);
        idx = ((luma >> GAMMA_INDEX_SHIFT) << up) >> down;
        if (idx > TABLE_LAST) idx = TABLE_LAST;
        res.blue = gamma_lut[idx];
        res.green = gamma_lut[idx];
        res.red = gamma_lut[idx];
      end else begin
        res.blue = ~px.blue;
        res.green = ~px.green;
        res.red = ~px.red;
      end
      return res;
    endfunction

    function void note_request(pixel_t px);
      expected_pixels.push_back(transform_pixel(px));
    endfunction

    function void compare_field(string name, logic [CHAN_W-1:0] exp, logic [CHAN_W-1:0] act);
      if (exp !== act) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $time, got);
        mismatches++;
        return;
      end
      exp = expected_pixels.pop_front();
      compare_field("blue_out", exp.blue, got.blue);
      compare_field("green_out", exp.green, got.green);
      compare_field("red_out", exp.red, got.red);
      compare_field("row_end_out", CHAN_W'(exp.row_end), CHAN_W'(got.row_end));
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic [CHAN_W-1:0] blue_in = '0;
  logic [CHAN_W-1:0] green_in = '0;
  logic [CHAN_W-1:0] red_in = '0;
  logic              row_end_in = 1'b0;
  logic              done;
  logic [CHAN_W-1:0] blue_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] red_out;
  logic              row_end_out;

  pixel_ledger ledger;

  rgb_invert_or_grayscale uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .blue_in     (blue_in),
    .green_in    (green_in),
    .red_in      (red_in),
    .row_end_in  (row_end_in),
    .done        (done),
    .blue_out    (blue_out),
    .green_out   (green_out),
    .red_out     (red_out),
    .row_end_out (row_end_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) ledger.check_pixel({blue_out, green_out, red_out, row_end_out});
  end

  // entered and left at a falling edge; start stays high for a back-to-back request
  task automatic send_pixel(input pixel_t px, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    blue_in <= px.blue;
    green_in <= px.green;
    red_in <= px.red;
    row_end_in <= px.row_end;
    @(posedge clk);
    while (busy) begin
      @(negedge clk);
      @(posedge clk);
    end
    ledger.note_request(px);
    @(negedge clk);
  endtask

  task automatic drain_and_set_mode(input logic m);
    start <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (PIPE_DEPTH) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    ledger.mode = m;
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    int     kind;
    kind = $urandom_range(0, 5);
    case (kind)
      1: begin
        px.blue = CHAN_W'($urandom);
        px.green = px.blue;
        px.red = px.blue;
      end
      2: begin
        px.blue = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        px.green = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        px.red = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
      3: begin
        // dark pixels land in and just past the linear segment
        px.blue = CHAN_W'($urandom_range(0, 3));
        px.green = CHAN_W'($urandom_range(0, 3));
        px.red = CHAN_W'($urandom_range(0, 3));
      end
      4: begin
        px.blue = CHAN_W'($urandom_range(250, 255));
        px.green = CHAN_W'($urandom_range(250, 255));
        px.red = CHAN_W'($urandom_range(250, 255));
      end
      default: begin
        px.blue = CHAN_W'($urandom);
        px.green = CHAN_W'($urandom);
        px.red = CHAN_W'($urandom);
      end
    endcase
    px.row_end = ($urandom_range(0, 7) == 0);
    return px;
  endfunction

  task automatic run_random(input int count);
    int left;
    int chunk;
    bit burst;
    left = count;
    while (left > 0) begin
      chunk = $urandom_range(10, 60);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < chunk && left > 0; i++) begin
        send_pixel(random_pixel(), burst ? 0 : $urandom_range(0, 10));
        left--;
      end
    end
  endtask

  initial begin
    pixel_t corner [12];
    ledger = new();
    corner = '{
      {8'h00, 8'h00, 8'h00, 1'b0},  // black
      {8'hFF, 8'hFF, 8'hFF, 1'b1},  // white, top of the gamma table
      {8'h00, 8'h00, 8'hFF, 1'b0},
      {8'h00, 8'hFF, 8'h00, 1'b1},
      {8'hFF, 8'h00, 8'h00, 1'b0},
      {8'h01, 8'h01, 8'h01, 1'b1},  // first entry past the linear segment
      {8'h00, 8'h01, 8'h00, 1'b0},
      {8'h00, 8'h00, 8'h02, 1'b1},
      {8'h00, 8'h01, 8'h01, 1'b0},
      {8'h55, 8'hAA, 8'h55, 1'b1},
      {8'hAA, 8'h55, 8'hAA, 1'b0},
      {8'h7F, 8'h80, 8'h7F, 1'b1}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    drain_and_set_mode(MODE_INVERT);
    foreach (corner[i]) send_pixel(corner[i], $urandom_range(0, 10));
    drain_and_set_mode(MODE_GRAY);
    foreach (corner[i]) send_pixel(corner[i], $urandom_range(0, 10));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_and_set_mode((p % 3 == 1) ? MODE_INVERT : MODE_GRAY);
      run_random(PHASE_ITEMS);
    end

    start <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (PIPE_DEPTH * 4) @(negedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
